### src/bsm_pkg.sv
package bsm_pkg;

    localparam int MAX_NODES_DEF  = 1024;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NODE_COUNT_RST = 1024;

    localparam int NODE_W      = 10;
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 64;
    localparam int CFG_W       = 11;
    localparam int MODE_W      = 2;
    localparam int IN_TDATA_W  = 304;
    localparam int OUT_TDATA_W = 112;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLOCK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EMPTY = 2'd2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] OUT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic add;
        logic emit;
        logic zero;
    } t_ctl;

    function automatic logic signed [ACC_W-1:0] sat_add64(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W-1:0] s;
        s = a + b;
        if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
            s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_out32(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [DATA_W-1:0] r;
        if (v > OUT_MAX) begin
            r = OUT_MAX[DATA_W-1:0];
        end else if (v < OUT_MIN) begin
            r = OUT_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/bsm_row_dot.sv
module bsm_row_dot #(
    parameter int FRAC_BITS = bsm_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [bsm_pkg::DATA_W-1:0]     i_a,
    input  logic signed [bsm_pkg::DATA_W-1:0]     i_b,
    input  logic signed [bsm_pkg::DATA_W-1:0]     i_c,
    input  logic signed [bsm_pkg::DATA_W-1:0]     i_vx,
    input  logic signed [bsm_pkg::DATA_W-1:0]     i_vy,
    input  logic signed [bsm_pkg::DATA_W-1:0]     i_vz,
    output logic signed [bsm_pkg::ACC_W-1:0]      o_dot
);

    logic signed [bsm_pkg::ACC_W-1:0] n_p0, n_p1, n_p2;
    logic signed [bsm_pkg::ACC_W-1:0] r_p0, r_p1, r_p2;
    logic signed [bsm_pkg::ACC_W-1:0] n_s01, r_s01, r_p2s;
    logic signed [bsm_pkg::ACC_W-1:0] r_dot;

    always_comb begin
        n_p0  = i_a * i_vx;
        n_p1  = i_b * i_vy;
        n_p2  = i_c * i_vz;
        n_s01 = bsm_pkg::sat_add64(r_p0 >>> FRAC_BITS, r_p1 >>> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= n_p0;
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_s01 <= n_s01;
            r_p2s <= r_p2 >>> FRAC_BITS;
            r_dot <= bsm_pkg::sat_add64(r_s01, r_p2s);
        end
    end

    assign o_dot = r_dot;

endmodule

### src/block_sparse_matvec.sv
// Block-sparse 3x3 matrix times vector in signed fixed point. Vector nodes are
// loaded first (tuser mode 0), then blocks stream in row order (mode 1), each
// multiplied by its column node's vector and summed into a row accumulator;
// the block with tlast closes the row and one transfer gives the row node and
// three saturated components. Mode 2 gives an empty row of zeros. One item is
// taken every cycle while the output side keeps up; a row result passes the
// vector store read, the product register, two saturating adds and the
// output register fed by the accumulator sum after its closing item is accepted.
// The user must write the node count only while no item is in flight; the block itself does not enforce it.
module block_sparse_matvec #(
    parameter int MAX_NODES = bsm_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = bsm_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bsm_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // column_node, e00, e01, e02, e10, e11, e12, e20, e21, e22, zero fill
    input  logic [bsm_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // mode
    input  logic [bsm_pkg::MODE_W-1:0]          i_s_tuser,
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // row_node, out_x, out_y, out_z, zero fill
    output logic [bsm_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    localparam int ADDR_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int COUNT_RST = (bsm_pkg::NODE_COUNT_RST > MAX_NODES) ?
                               MAX_NODES : bsm_pkg::NODE_COUNT_RST;
    localparam int DW        = bsm_pkg::DATA_W;
    localparam int NW        = bsm_pkg::NODE_W;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              en, accept;
    logic [NW-1:0]     in_node;
    logic [ADDR_W-1:0] in_addr;
    logic              in_range;
    bsm_pkg::t_ctl     n_c1, r_c1, r_c2, r_c3, r_c4;

    logic [3*DW-1:0]   mem [MAX_NODES];
    logic [3*DW-1:0]   r_vec;
    logic signed [DW-1:0] r_e [9];

    logic signed [bsm_pkg::ACC_W-1:0] dot_x, dot_y, dot_z;
    logic signed [bsm_pkg::ACC_W-1:0] r_acc_x, r_acc_y, r_acc_z;
    logic signed [bsm_pkg::ACC_W-1:0] n_acc_x, n_acc_y, n_acc_z;
    logic [ADDR_W-1:0] r_row;
    logic [ADDR_W:0]   row_inc;
    logic [ADDR_W-1:0] n_row;
    logic              r_out_valid;
    logic signed [DW-1:0] n_ox, n_oy, n_oz;
    logic [NW-1:0]     r_out_node;
    logic signed [DW-1:0] r_ox, r_oy, r_oz;

    assign o_cfg_ready = 1'b1;
    assign en          = !r_out_valid || i_m_tready;
    assign o_s_tready  = en;
    assign accept      = i_s_tvalid && en;
    assign in_node     = i_s_tdata[NW-1:0];
    assign in_addr     = ADDR_W'(in_node);
    assign in_range    = 32'(in_node) < 32'(r_count);

    always_comb begin
        if (i_cfg_data == '0) begin
            n_count = CNT_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_NODES)) begin
            n_count = CNT_W'(MAX_NODES);
        end else begin
            n_count = CNT_W'(i_cfg_data);
        end
    end

    always_comb begin
        n_c1.add  = accept && (i_s_tuser == bsm_pkg::MODE_BLOCK) && in_range;
        n_c1.emit = accept && (((i_s_tuser == bsm_pkg::MODE_BLOCK) && i_s_tlast)
                    || (i_s_tuser == bsm_pkg::MODE_EMPTY));
        n_c1.zero = i_s_tuser == bsm_pkg::MODE_EMPTY;
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_s_tuser == bsm_pkg::MODE_LOAD) && in_range) begin
            mem[in_addr] <= i_s_tdata[NW+3*DW-1:NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vec <= mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < 9; k++) begin
                r_e[k] <= i_s_tdata[NW + DW*k +: DW];
            end
        end
    end

    bsm_row_dot #(.FRAC_BITS(FRAC_BITS)) u_row_x (
        .i_clk (i_clk), .i_en (en),
        .i_a   (r_e[0]), .i_b (r_e[1]), .i_c (r_e[2]),
        .i_vx  (r_vec[DW-1:0]), .i_vy (r_vec[2*DW-1:DW]), .i_vz (r_vec[3*DW-1:2*DW]),
        .o_dot (dot_x)
    );

    bsm_row_dot #(.FRAC_BITS(FRAC_BITS)) u_row_y (
        .i_clk (i_clk), .i_en (en),
        .i_a   (r_e[3]), .i_b (r_e[4]), .i_c (r_e[5]),
        .i_vx  (r_vec[DW-1:0]), .i_vy (r_vec[2*DW-1:DW]), .i_vz (r_vec[3*DW-1:2*DW]),
        .o_dot (dot_y)
    );

    bsm_row_dot #(.FRAC_BITS(FRAC_BITS)) u_row_z (
        .i_clk (i_clk), .i_en (en),
        .i_a   (r_e[6]), .i_b (r_e[7]), .i_c (r_e[8]),
        .i_vx  (r_vec[DW-1:0]), .i_vy (r_vec[2*DW-1:DW]), .i_vz (r_vec[3*DW-1:2*DW]),
        .o_dot (dot_z)
    );

    always_comb begin
        n_acc_x = r_c4.add ? bsm_pkg::sat_add64(r_acc_x, dot_x) : r_acc_x;
        n_acc_y = r_c4.add ? bsm_pkg::sat_add64(r_acc_y, dot_y) : r_acc_y;
        n_acc_z = r_c4.add ? bsm_pkg::sat_add64(r_acc_z, dot_z) : r_acc_z;
        row_inc = {1'b0, r_row} + (ADDR_W+1)'(1);
        n_row   = (32'(row_inc) >= 32'(r_count)) ? '0 : row_inc[ADDR_W-1:0];
        if (r_c4.zero) begin
            n_ox = '0;
            n_oy = '0;
            n_oz = '0;
        end else begin
            n_ox = bsm_pkg::sat_out32(n_acc_x);
            n_oy = bsm_pkg::sat_out32(n_acc_y);
            n_oz = bsm_pkg::sat_out32(n_acc_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CNT_W'(COUNT_RST);
            r_c1        <= '0;
            r_c2        <= '0;
            r_c3        <= '0;
            r_c4        <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_acc_z     <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_count <= n_count;
            end
            if (en) begin
                r_c1        <= n_c1;
                r_c2        <= r_c1;
                r_c3        <= r_c2;
                r_c4        <= r_c3;
                r_out_valid <= r_c4.emit;
                if (r_c4.emit) begin
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                    r_acc_z <= '0;
                    r_row   <= n_row;
                end else begin
                    r_acc_x <= n_acc_x;
                    r_acc_y <= n_acc_y;
                    r_acc_z <= n_acc_z;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_c4.emit) begin
            r_out_node <= NW'(r_row);
            r_ox       <= n_ox;
            r_oy       <= n_oy;
            r_oz       <= n_oz;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(bsm_pkg::OUT_TDATA_W - NW - 3*DW)'(0), r_oz, r_oy, r_ox, r_out_node};

endmodule

### tb/sv/block_sparse_matvec_tb.sv
`timescale 1ns / 1ps

module block_sparse_matvec_tb;

    localparam logic [bsm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int                         ROW_LATENCY = 20;

    localparam logic [bsm_pkg::DATA_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [bsm_pkg::DATA_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [bsm_pkg::DATA_W-1:0] Q_HALF    = 32'h0000_8000;
    localparam logic [bsm_pkg::DATA_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [bsm_pkg::DATA_W-1:0] Q_MIN     = 32'h8000_0000;

    localparam logic signed [bsm_pkg::ACC_W-1:0] LIM64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [bsm_pkg::ACC_W-1:0] LIM64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [bsm_pkg::ACC_W-1:0] LIM32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [bsm_pkg::ACC_W-1:0] LIM32_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic [bsm_pkg::MODE_W-1:0]       mode;
        logic                             last;
        logic [bsm_pkg::NODE_W-1:0]       node;
        logic [8:0][bsm_pkg::DATA_W-1:0]  ent;
    } t_blk_item;

    typedef struct packed {
        logic [bsm_pkg::NODE_W-1:0] node;
        logic [bsm_pkg::DATA_W-1:0] x;
        logic [bsm_pkg::DATA_W-1:0] y;
        logic [bsm_pkg::DATA_W-1:0] z;
    } t_row_out;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [bsm_pkg::CFG_W-1:0]       i_cfg_data  = '0;
    logic                            i_s_tvalid  = 1'b0;
    logic                            o_s_tready;
    logic [bsm_pkg::IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic [bsm_pkg::MODE_W-1:0]      i_s_tuser   = '0;
    logic                            i_s_tlast   = 1'b0;
    logic                            o_m_tvalid;
    logic                            i_m_tready  = 1'b0;
    logic [bsm_pkg::OUT_TDATA_W-1:0] o_m_tdata;

    t_blk_item pending_items[$];
    t_row_out  expected_rows[$];
    t_blk_item drv_item;

    logic              s_took     = 1'b0;
    logic              calm       = 1'b0;
    int                send_gap   = 0;
    int                stall_left = 0;
    int                mismatches = 0;

    logic signed [bsm_pkg::DATA_W-1:0] vec_x [0:bsm_pkg::MAX_NODES_DEF-1];
    logic signed [bsm_pkg::DATA_W-1:0] vec_y [0:bsm_pkg::MAX_NODES_DEF-1];
    logic signed [bsm_pkg::DATA_W-1:0] vec_z [0:bsm_pkg::MAX_NODES_DEF-1];
    logic signed [bsm_pkg::ACC_W-1:0]  row_acc [0:2];
    logic [bsm_pkg::NODE_W-1:0]        row_ctr  = '0;
    logic [bsm_pkg::CFG_W-1:0]         node_cfg = 11'd1024;

    block_sparse_matvec uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned eff_count(input logic [bsm_pkg::CFG_W-1:0] c);
        if (c == 0) begin
            return 1;
        end
        if (c > bsm_pkg::MAX_NODES_DEF) begin
            return bsm_pkg::MAX_NODES_DEF;
        end
        return 32'(c);
    endfunction

    function automatic logic signed [bsm_pkg::ACC_W-1:0] add_sat(
        input logic signed [bsm_pkg::ACC_W-1:0] a,
        input logic signed [bsm_pkg::ACC_W-1:0] b
    );
        logic signed [bsm_pkg::ACC_W:0] s;
        s = {a[bsm_pkg::ACC_W-1], a} + {b[bsm_pkg::ACC_W-1], b};
        if (s[bsm_pkg::ACC_W] != s[bsm_pkg::ACC_W-1]) begin
            return s[bsm_pkg::ACC_W] ? LIM64_MIN : LIM64_MAX;
        end
        return s[bsm_pkg::ACC_W-1:0];
    endfunction

    function automatic logic signed [bsm_pkg::ACC_W-1:0] scaled_prod(
        input logic signed [bsm_pkg::DATA_W-1:0] a,
        input logic signed [bsm_pkg::DATA_W-1:0] b
    );
        logic signed [bsm_pkg::ACC_W-1:0] p;
        p = a * b;
        return p >>> bsm_pkg::FRAC_BITS_DEF;
    endfunction

    function automatic logic [bsm_pkg::DATA_W-1:0] clip32(
        input logic signed [bsm_pkg::ACC_W-1:0] v
    );
        if (v > LIM32_MAX) begin
            return LIM32_MAX[bsm_pkg::DATA_W-1:0];
        end
        if (v < LIM32_MIN) begin
            return LIM32_MIN[bsm_pkg::DATA_W-1:0];
        end
        return v[bsm_pkg::DATA_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [bsm_pkg::DATA_W-1:0] rand_entry();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            4: return $urandom_range(0, 1) ? Q_ONE : Q_NEG_ONE;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [8:0][bsm_pkg::DATA_W-1:0] rand_ents();
        logic [8:0][bsm_pkg::DATA_W-1:0] e;
        for (int k = 0; k < 9; k++) begin
            e[k] = rand_entry();
        end
        return e;
    endfunction

    task automatic emit_row(
        input logic signed [bsm_pkg::ACC_W-1:0] x,
        input logic signed [bsm_pkg::ACC_W-1:0] y,
        input logic signed [bsm_pkg::ACC_W-1:0] z
    );
        t_row_out    res;
        int unsigned nxt;
        res.node = row_ctr;
        res.x    = clip32(x);
        res.y    = clip32(y);
        res.z    = clip32(z);
        expected_rows.insert(expected_rows.size(), res);
        nxt = row_ctr + 1;
        row_ctr = (nxt >= eff_count(node_cfg)) ? '0 : nxt[bsm_pkg::NODE_W-1:0];
        for (int r = 0; r < 3; r++) begin
            row_acc[r] = '0;
        end
    endtask

    task automatic step_matvec(
        input logic [bsm_pkg::MODE_W-1:0]      md,
        input logic [bsm_pkg::NODE_W-1:0]      nd,
        input logic                            lst,
        input logic [8:0][bsm_pkg::DATA_W-1:0] ent
    );
        int unsigned                      cnt;
        logic signed [bsm_pkg::ACC_W-1:0]  part;
        logic signed [bsm_pkg::DATA_W-1:0] vx, vy, vz;
        cnt = eff_count(node_cfg);
        case (md)
            bsm_pkg::MODE_LOAD: begin
                if (nd < cnt) begin
                    vec_x[nd] = ent[0];
                    vec_y[nd] = ent[1];
                    vec_z[nd] = ent[2];
                end
            end
            bsm_pkg::MODE_BLOCK: begin
                if (nd < cnt) begin
                    vx = vec_x[nd];
                    vy = vec_y[nd];
                    vz = vec_z[nd];
                    for (int r = 0; r < 3; r++) begin
                        part = scaled_prod(ent[3*r], vx);
                        part = add_sat(part, scaled_prod(ent[3*r+1], vy));
                        part = add_sat(part, scaled_prod(ent[3*r+2], vz));
                        row_acc[r] = add_sat(row_acc[r], part);
                    end
                end
                if (lst) begin
                    emit_row(row_acc[0], row_acc[1], row_acc[2]);
                end
            end
            bsm_pkg::MODE_EMPTY: begin
                emit_row('0, '0, '0);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_row(input logic [bsm_pkg::OUT_TDATA_W-1:0] d);
        t_row_out got;
        t_row_out want;
        got.node = d[bsm_pkg::NODE_W-1:0];
        got.x    = d[bsm_pkg::NODE_W +: bsm_pkg::DATA_W];
        got.y    = d[bsm_pkg::NODE_W+bsm_pkg::DATA_W +: bsm_pkg::DATA_W];
        got.z    = d[bsm_pkg::NODE_W+2*bsm_pkg::DATA_W +: bsm_pkg::DATA_W];
        if (expected_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected row transfer: row %0d x %0d y %0d z %0d",
                         got.node, $signed(got.x), $signed(got.y), $signed(got.z));
            end
        end else begin
            want = expected_rows.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"Row mismatch: expected row %0d x %0d y %0d z %0d, ",
                              "got row %0d x %0d y %0d z %0d"},
                             want.node, $signed(want.x), $signed(want.y),
                             $signed(want.z), got.node, $signed(got.x),
                             $signed(got.y), $signed(got.z));
                end
            end
        end
    endtask

    initial begin
        for (int r = 0; r < 3; r++) begin
            row_acc[r] = '0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_took <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                check_row(o_m_tdata);
            end
            if (i_s_tvalid && o_s_tready) begin
                step_matvec(i_s_tuser, i_s_tdata[bsm_pkg::NODE_W-1:0], i_s_tlast,
                            i_s_tdata[bsm_pkg::NODE_W +: 9*bsm_pkg::DATA_W]);
            end
            s_took <= i_s_tvalid && o_s_tready;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_took) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                drv_item = pending_items.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {{(bsm_pkg::IN_TDATA_W-bsm_pkg::NODE_W-9*bsm_pkg::DATA_W){1'b0}},
                               drv_item.ent, drv_item.node};
                i_s_tuser  <= drv_item.mode;
                i_s_tlast  <= drv_item.last;
                send_gap = calm ? 0 : pick_gap();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = pick_gap() + 1;
            end
        end
    end

    task automatic push_item(
        input logic [bsm_pkg::MODE_W-1:0]      md,
        input logic [bsm_pkg::NODE_W-1:0]      nd,
        input logic                            lst,
        input logic [8:0][bsm_pkg::DATA_W-1:0] ent
    );
        t_blk_item it;
        it.mode = md;
        it.node = nd;
        it.last = lst;
        it.ent  = ent;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || i_s_tvalid || expected_rows.size() != 0) begin
            @(negedge i_clk);
            #1;
        end
        repeat (ROW_LATENCY) @(negedge i_clk);
    endtask

    task automatic write_node_count(input logic [bsm_pkg::CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        node_cfg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int n_items);
        int unsigned                cnt;
        int                         sent;
        int                         nb;
        int                         r;
        int                         seeds;
        logic [bsm_pkg::NODE_W-1:0] nd;
        int                         live[$];
        cnt   = eff_count(node_cfg);
        sent  = 0;
        seeds = (cnt < 6) ? int'(cnt) : 6;
        for (int k = 0; k < seeds; k++) begin
            nd = (k == 0) ? '0 : bsm_pkg::NODE_W'($urandom_range(0, cnt - 1));
            push_item(bsm_pkg::MODE_LOAD, nd, 1'($urandom_range(0, 1)), rand_ents());
            live.insert(live.size(), int'(nd));
            sent++;
        end
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                nb = $urandom_range(1, 4);
                for (int k = 0; k < nb; k++) begin
                    nd = bsm_pkg::NODE_W'(live[$urandom_range(0, live.size() - 1)]);
                    push_item(bsm_pkg::MODE_BLOCK, nd, k == nb - 1, rand_ents());
                    sent++;
                end
            end else if (r < 80) begin
                nd = bsm_pkg::NODE_W'($urandom_range(0, cnt - 1));
                push_item(bsm_pkg::MODE_LOAD, nd, 1'($urandom_range(0, 1)), rand_ents());
                live.insert(live.size(), int'(nd));
                sent++;
            end else if (r < 85) begin
                push_item(bsm_pkg::MODE_EMPTY, bsm_pkg::NODE_W'($urandom()),
                          1'($urandom_range(0, 1)), rand_ents());
                sent++;
            end else if (r < 90) begin
                push_item(MODE_UNUSED, bsm_pkg::NODE_W'($urandom()),
                          1'($urandom_range(0, 1)), rand_ents());
                sent++;
            end else if (r < 95 && cnt < bsm_pkg::MAX_NODES_DEF) begin
                // A load at or above the node count must leave the store untouched.
                push_item(bsm_pkg::MODE_LOAD,
                          bsm_pkg::NODE_W'($urandom_range(cnt, bsm_pkg::MAX_NODES_DEF - 1)),
                          1'($urandom_range(0, 1)), rand_ents());
                sent++;
            end else if (cnt < bsm_pkg::MAX_NODES_DEF && $urandom_range(0, 1)) begin
                push_item(bsm_pkg::MODE_BLOCK,
                          bsm_pkg::NODE_W'($urandom_range(cnt, bsm_pkg::MAX_NODES_DEF - 1)),
                          1'($urandom_range(0, 1)), rand_ents());
                sent++;
            end else begin
                // A partial row cut short by an empty row.
                nd = bsm_pkg::NODE_W'(live[$urandom_range(0, live.size() - 1)]);
                push_item(bsm_pkg::MODE_BLOCK, nd, 1'b0, rand_ents());
                push_item(bsm_pkg::MODE_EMPTY, bsm_pkg::NODE_W'($urandom()),
                          1'($urandom_range(0, 1)), rand_ents());
                sent += 2;
            end
        end
    endtask

    initial begin
        int counts[10];
        counts = '{11'd3, 11'd1, 11'd1024, 11'd2047, 11'd17,
                   11'd1025, 11'd64, 11'd0, 11'd200, 11'd2};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_item(bsm_pkg::MODE_LOAD, 10'd0, 1'b0, {192'd0, 32'd0, Q_MIN, Q_MAX});
        push_item(bsm_pkg::MODE_LOAD, 10'd1023, 1'b0, {9{Q_MAX}});
        push_item(bsm_pkg::MODE_LOAD, 10'd5, 1'b1, {192'd0, Q_HALF, Q_NEG_ONE, Q_ONE});
        push_item(bsm_pkg::MODE_BLOCK, 10'd0, 1'b0, {9{Q_MAX}});
        push_item(bsm_pkg::MODE_BLOCK, 10'd1023, 1'b1, {9{Q_MIN}});
        push_item(bsm_pkg::MODE_BLOCK, 10'd5, 1'b1,
                  {Q_ONE, 96'd0, Q_ONE, 96'd0, Q_ONE});
        push_item(bsm_pkg::MODE_EMPTY, 10'd0, 1'b0, '0);
        push_item(bsm_pkg::MODE_BLOCK, 10'd5, 1'b0, {9{Q_MAX}});
        push_item(bsm_pkg::MODE_EMPTY, 10'h3FF, 1'b1, {9{32'hFFFF_FFFF}});
        push_item(MODE_UNUSED, 10'h3FF, 1'b1, {9{32'hFFFF_FFFF}});
        push_item(bsm_pkg::MODE_LOAD, 10'd1023, 1'b0, rand_ents());
        push_item(bsm_pkg::MODE_BLOCK, 10'd1023, 1'b1, rand_ents());
        push_item(bsm_pkg::MODE_BLOCK, 10'd0, 1'b1, {9{32'hFFFF_FFFF}});
        push_item(bsm_pkg::MODE_BLOCK, 10'd5, 1'b0, {9{Q_MIN}});
        push_item(bsm_pkg::MODE_BLOCK, 10'd0, 1'b1, {9{Q_MIN}});
        wait_idle();

        // A zero count behaves as one node, so every row wraps at once.
        write_node_count(11'd0);
        push_item(bsm_pkg::MODE_LOAD, 10'd0, 1'b0, rand_ents());
        push_item(bsm_pkg::MODE_LOAD, 10'd1, 1'b0, {9{Q_MAX}});
        push_item(bsm_pkg::MODE_BLOCK, 10'd0, 1'b1, rand_ents());
        push_item(bsm_pkg::MODE_BLOCK, 10'd900, 1'b1, {9{Q_MAX}});
        push_item(bsm_pkg::MODE_BLOCK, 10'd0, 1'b0, rand_ents());
        push_item(bsm_pkg::MODE_BLOCK, 10'd1, 1'b1, rand_ents());
        push_item(bsm_pkg::MODE_EMPTY, 10'd0, 1'b0, '0);
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            calm = (ph % 4 == 1);
            write_node_count(11'(counts[ph]));
            random_phase(91);
            wait_idle();
        end
        calm = 1'b0;

        if (mismatches == 0 && expected_rows.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
